>>> design/tmff_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the CORDIC angle table for the magic formula tire force block.
// No dependencies.
package tmff_pkg;

	localparam int FRAC              = 16;
	localparam int CORDIC_STAGES_DEF = 18;

	localparam int SLIP_W  = 22;
	localparam int MU_W    = 18;
	localparam int FORCE_W = 35;
	localparam int B_W     = 21;
	localparam int C_W     = 19;
	localparam int D_W     = 18;
	localparam int E_W     = 22;
	localparam int SV_W    = 18;
	localparam int SH_W    = 18;
	localparam int LOAD_W  = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	localparam int ANG_W        = 33;
	localparam int ARG_W        = 37;
	localparam int RED_W        = 35;
	localparam int ARG_HI_SHIFT = 20;
	localparam int RECIP_W      = 15;
	localparam int RECIP_SHIFT  = 26;
	localparam int K_W          = 6;

	localparam logic signed [ANG_W-1:0] GAIN_Q30    = 33'sd652032874;
	localparam logic signed [RED_W-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic [RECIP_W-1:0]      RECIP_2PI   = 15'd10430;

	localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

	localparam logic [30:0] ANGLE_TAB [32] = '{
		31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
		31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
		31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
		31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
		31'd127, 31'd63, 31'd31, 31'd15, 31'd7, 31'd3, 31'd1, 31'd0, 31'd0
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STIFFNESS_B      = 3'd0,
		CFG_SHAPE_C          = 3'd1,
		CFG_PEAK_D           = 3'd2,
		CFG_CURVATURE_E      = 3'd3,
		CFG_VERTICAL_SHIFT   = 3'd4,
		CFG_HORIZONTAL_SHIFT = 3'd5,
		CFG_NOMINAL_LOAD     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	function automatic logic signed [ANG_W-1:0] angle_at(input int k);
		logic [4:0] idx;
		idx = k[4:0];
		return $signed({2'b00, ANGLE_TAB[idx]});
	endfunction

endpackage

>>> design/tmff_in_if.sv
`timescale 1ns / 1ps
// Input channel: slip and friction coefficient with valid/ready.
// Depends on tmff_pkg.
interface tmff_in_if import tmff_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [SLIP_W-1:0] slip;
	logic [MU_W-1:0]          friction_coefficient;

	modport source (output valid, output slip, output friction_coefficient, input ready);
	modport sink (input valid, input slip, input friction_coefficient, output ready);
endinterface

>>> design/tmff_out_if.sv
`timescale 1ns / 1ps
// Output channel: tire force and saturation flag with valid/ready.
// Depends on tmff_pkg.
interface tmff_out_if import tmff_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FORCE_W-1:0] force_res;
	logic                      saturated;

	modport source (output valid, output force_res, output saturated, input ready);
	modport sink (input valid, input force_res, input saturated, output ready);
endinterface

>>> design/tmff_atan_pipe.sv
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring unit: arctangent of a Q30 value, one stage per iteration.
// Depends on tmff_pkg.
module tmff_atan_pipe import tmff_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF,
	parameter int W      = 46,
	parameter int SIDE_W = 18
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pipe_ctl_t               ctl,
	input  logic signed [W-1:0]     y_in,
	input  logic [SIDE_W-1:0]       side_in,
	output logic                    vld_out,
	output logic signed [ANG_W-1:0] z_out,
	output logic [SIDE_W-1:0]       side_out
);

	logic signed [W-1:0]     x_s    [STAGES+1];
	logic signed [W-1:0]     y_s    [STAGES+1];
	logic signed [ANG_W-1:0] z_s    [STAGES+1];
	logic [SIDE_W-1:0]       side_s [STAGES+1];
	logic                    vld_s  [STAGES+1];

	assign x_s[0]    = W'(1073741824);
	assign y_s[0]    = y_in;
	assign z_s[0]    = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = ctl.vld;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				side_s[i+1] <= side_s[i];
				if (y_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - angle_at(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + angle_at(i);
				end
			end
		end
	end

	assign vld_out  = vld_s[STAGES];
	assign z_out    = z_s[STAGES];
	assign side_out = side_s[STAGES];

endmodule

>>> design/tmff_angle_reduce.sv
`timescale 1ns / 1ps
// Four-stage angle reduction: wrap a Q30 angle into (-pi, pi], then fold into [-pi/2, pi/2].
// Depends on tmff_pkg.
module tmff_angle_reduce import tmff_pkg::*; #(
	parameter int SIDE_W = 18
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pipe_ctl_t               ctl,
	input  logic signed [ARG_W-1:0] arg_in,
	input  logic [SIDE_W-1:0]       side_in,
	output logic                    vld_out,
	output logic signed [ANG_W-1:0] z_out,
	output logic [SIDE_W-1:0]       side_out
);

	localparam int HI_W = ARG_W - ARG_HI_SHIFT;
	localparam int KP_W = HI_W + RECIP_W + 1;
	localparam int RP_W = K_W + RED_W;

	logic signed [HI_W-1:0]  a_hi;
	logic signed [KP_W-1:0]  k_prod;
	logic signed [RP_W-1:0]  r_prod;
	logic signed [RP_W-1:0]  r_full;

	logic signed [K_W-1:0]   k_s1;
	logic signed [ARG_W-1:0] arg_s1;
	logic signed [RED_W-1:0] r_s2;
	logic signed [RED_W-1:0] c_s3;
	logic signed [ANG_W-1:0] z_s4;
	logic [SIDE_W-1:0]       side_s1, side_s2, side_s3, side_s4;
	logic                    vld_s1, vld_s2, vld_s3, vld_s4;

	assign a_hi   = arg_in[ARG_W-1:ARG_HI_SHIFT];
	assign k_prod = KP_W'(a_hi) * $signed({1'b0, RECIP_2PI})
		+ (KP_W'(1) <<< (RECIP_SHIFT - 1));
	assign r_prod = RP_W'(k_s1) * RP_W'(TWO_PI_Q30);
	assign r_full = RP_W'(arg_s1) - r_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			k_s1    <= k_prod[RECIP_SHIFT+K_W-1:RECIP_SHIFT];
			arg_s1  <= arg_in;
			side_s1 <= side_in;

			r_s2    <= r_full[RED_W-1:0];
			side_s2 <= side_s1;

			if (r_s2 > PI_Q30) begin
				c_s3 <= r_s2 - TWO_PI_Q30;
			end else if (r_s2 <= -PI_Q30) begin
				c_s3 <= r_s2 + TWO_PI_Q30;
			end else begin
				c_s3 <= r_s2;
			end
			side_s3 <= side_s2;

			if (c_s3 > HALF_PI_Q30) begin
				z_s4 <= ANG_W'(PI_Q30 - c_s3);
			end else if (c_s3 < -HALF_PI_Q30) begin
				z_s4 <= ANG_W'(-PI_Q30 - c_s3);
			end else begin
				z_s4 <= ANG_W'(c_s3);
			end
			side_s4 <= side_s3;
		end
	end

	assign vld_out  = vld_s4;
	assign z_out    = z_s4;
	assign side_out = side_s4;

endmodule

>>> design/tmff_sin_pipe.sv
`timescale 1ns / 1ps
// Pipelined CORDIC rotation unit: sine of a Q30 angle in [-pi/2, pi/2], one stage per iteration.
// Depends on tmff_pkg.
module tmff_sin_pipe import tmff_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF,
	parameter int W      = 34,
	parameter int SIDE_W = 18
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pipe_ctl_t               ctl,
	input  logic signed [ANG_W-1:0] z_in,
	input  logic [SIDE_W-1:0]       side_in,
	output logic                    vld_out,
	output logic signed [W-1:0]     sin_out,
	output logic [SIDE_W-1:0]       side_out
);

	logic signed [W-1:0]     x_s    [STAGES+1];
	logic signed [W-1:0]     y_s    [STAGES+1];
	logic signed [ANG_W-1:0] z_s    [STAGES+1];
	logic [SIDE_W-1:0]       side_s [STAGES+1];
	logic                    vld_s  [STAGES+1];

	assign x_s[0]    = W'(GAIN_Q30);
	assign y_s[0]    = '0;
	assign z_s[0]    = z_in;
	assign side_s[0] = side_in;
	assign vld_s[0]  = ctl.vld;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				side_s[i+1] <= side_s[i];
				if (!z_s[i][ANG_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - angle_at(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + angle_at(i);
				end
			end
		end
	end

	assign vld_out  = vld_s[STAGES];
	assign sin_out  = y_s[STAGES];
	assign side_out = side_s[STAGES];

endmodule

>>> design/tire_magic_formula_force_top.sv
`timescale 1ns / 1ps
// Top level of the magic formula tire force pipeline: configuration registers, multiplier
// stages, output register and skid buffer. Depends on tmff_pkg, the channel interfaces and
// tmff_atan_pipe, tmff_angle_reduce and tmff_sin_pipe.
//
// Computes force = mu * load * (D*sin(C*atan(B*(1-E)*x + E*atan(B*x))) + Sv) with x = slip + Sh,
// in signed fixed point with 16 fraction bits, saturated to 35 bits. One transaction is
// accepted every clock while the skid buffer is empty. Each transaction passes through the two
// arctangent CORDIC pipelines and the sine CORDIC pipeline, one iteration per stage. A finished
// result waits in the output register and a one-entry skid buffer, so input ready drops only
// while the skid buffer holds a result. Coefficients must be written through the plain write
// port only while no transaction is in flight; the block itself does not enforce this.
module tire_magic_formula_force_top import tmff_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tmff_in_if.sink               item,
	tmff_out_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int X_W     = SLIP_W + 1;
	localparam int BX_W    = 28;
	localparam int AT_W    = ANG_W - (30 - FRAC);
	localparam int EA_W    = E_W + AT_W - FRAC;
	localparam int OME_W   = E_W + 1;
	localparam int T_W     = BX_W + OME_W - FRAC;
	localparam int U_W     = T_W + 1;
	localparam int ATAN1_W = BX_W + (30 - FRAC) + 4;
	localparam int ATAN2_W = U_W + (30 - FRAC) + 4;
	localparam int SIN_W   = 34;
	localparam int DS_W    = D_W + 1 + SIN_W;
	localparam int YV_W    = DS_W - 30 + 1;
	localparam int ML_W    = MU_W + LOAD_W;
	localparam int P_W     = ML_W + 1 + YV_W;
	localparam int F_W     = P_W - FRAC;

	logic [B_W-1:0]           b_q;
	logic [C_W-1:0]           c_q;
	logic [D_W-1:0]           d_q;
	logic signed [E_W-1:0]    e_q;
	logic signed [SV_W-1:0]   sv_q;
	logic signed [SH_W-1:0]   sh_q;
	logic [LOAD_W-1:0]        load_q;

	logic                     pipe_en;
	pipe_ctl_t                ctl;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [X_W-1:0]    x_s1;
	logic [MU_W-1:0]          mu_s1, mu_s2, mu_s3, mu_s4, mu_s5;
	logic signed [BX_W-1:0]   bx_s2;
	logic signed [EA_W-1:0]   ea_s3;
	logic signed [T_W-1:0]    t_s3;
	logic signed [U_W-1:0]    u_s4;
	logic signed [ARG_W-1:0]  arg_s5;
	logic signed [YV_W-1:0]   yv_s6;
	logic [ML_W-1:0]          ml_s6;
	logic signed [F_W-1:0]    f_s7;

	logic signed [FORCE_W-1:0] force_q, sk_force_q;
	logic                      sat_q, sk_sat_q, ov_q, sk_v_q;

	logic signed [B_W+X_W:0]        bx_prod;
	logic signed [ATAN1_W-1:0]      a1_y;
	logic                           a1_vld;
	logic signed [ANG_W-1:0]        a1_z;
	logic [MU_W+BX_W-1:0]           a1_side;
	logic signed [BX_W-1:0]         a1_bx;
	logic [MU_W-1:0]                a1_mu;
	logic signed [AT_W-1:0]         a1_at;
	logic signed [E_W+AT_W-1:0]     ea_prod;
	logic signed [OME_W-1:0]        ome;
	logic signed [BX_W+OME_W-1:0]   t_prod;
	logic signed [ATAN2_W-1:0]      a2_y;
	logic                           a2_vld;
	logic signed [ANG_W-1:0]        a2_z;
	logic [MU_W-1:0]                a2_mu;
	logic signed [C_W+1+ANG_W-1:0]  arg_prod;
	logic                           rd_vld;
	logic signed [ANG_W-1:0]        rd_z;
	logic [MU_W-1:0]                rd_mu;
	logic                           sn_vld;
	logic signed [SIN_W-1:0]        sn_y;
	logic [MU_W-1:0]                sn_mu;
	logic signed [DS_W-1:0]         ds_prod;
	logic signed [P_W-1:0]          p_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q    <= B_W'(32768);
			c_q    <= C_W'(108134);
			d_q    <= D_W'(65536);
			e_q    <= E_W'(52429);
			sv_q   <= '0;
			sh_q   <= '0;
			load_q <= LOAD_W'(1000);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_STIFFNESS_B:      b_q    <= cfg_data[B_W-1:0];
				CFG_SHAPE_C:          c_q    <= cfg_data[C_W-1:0];
				CFG_PEAK_D:           d_q    <= cfg_data[D_W-1:0];
				CFG_CURVATURE_E:      e_q    <= cfg_data[E_W-1:0];
				CFG_VERTICAL_SHIFT:   sv_q   <= cfg_data[SV_W-1:0];
				CFG_HORIZONTAL_SHIFT: sh_q   <= cfg_data[SH_W-1:0];
				CFG_NOMINAL_LOAD:     load_q <= cfg_data[LOAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign pipe_en    = !sk_v_q;
	assign item.ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			ov_q   <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= item.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= a1_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= a2_vld;
			vld_s6 <= sn_vld;
			vld_s7 <= vld_s6;
			ov_q   <= vld_s7;
		end
	end

	assign bx_prod  = $signed({1'b0, b_q}) * x_s1;
	assign a1_y     = ATAN1_W'(bx_s2) <<< (30 - FRAC);
	assign a1_bx    = a1_side[BX_W-1:0];
	assign a1_mu    = a1_side[MU_W+BX_W-1:BX_W];
	assign a1_at    = a1_z[ANG_W-1:30-FRAC];
	assign ea_prod  = (E_W+AT_W)'(e_q) * (E_W+AT_W)'(a1_at);
	assign ome      = OME_W'(1 << FRAC) - OME_W'(e_q);
	assign t_prod   = (BX_W+OME_W)'(a1_bx) * (BX_W+OME_W)'(ome);
	assign a2_y     = ATAN2_W'(u_s4) <<< (30 - FRAC);
	assign arg_prod = (C_W+1+ANG_W)'($signed({1'b0, c_q})) * (C_W+1+ANG_W)'(a2_z);
	assign ds_prod  = DS_W'($signed({1'b0, d_q})) * DS_W'(sn_y);
	assign p_prod   = P_W'($signed({1'b0, ml_s6})) * P_W'(yv_s6);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			x_s1  <= X_W'(item.slip) + X_W'(sh_q);
			mu_s1 <= item.friction_coefficient;

			bx_s2 <= bx_prod[FRAC+BX_W-1:FRAC];
			mu_s2 <= mu_s1;

			ea_s3 <= ea_prod[E_W+AT_W-1:FRAC];
			t_s3  <= t_prod[BX_W+OME_W-1:FRAC];
			mu_s3 <= a1_mu;

			u_s4  <= U_W'(t_s3) + U_W'(ea_s3);
			mu_s4 <= mu_s3;

			arg_s5 <= arg_prod[FRAC+ARG_W-1:FRAC];
			mu_s5  <= a2_mu;

			yv_s6 <= YV_W'($signed(ds_prod[DS_W-1:30])) + YV_W'(sv_q);
			ml_s6 <= ML_W'(sn_mu) * ML_W'(load_q);

			f_s7 <= p_prod[P_W-1:FRAC];

			if (f_s7 > F_W'(FORCE_MAX)) begin
				force_q <= FORCE_MAX;
				sat_q   <= 1'b1;
			end else if (f_s7 < F_W'(FORCE_MIN)) begin
				force_q <= FORCE_MIN;
				sat_q   <= 1'b1;
			end else begin
				force_q <= f_s7[FORCE_W-1:0];
				sat_q   <= 1'b0;
			end
		end
	end

	assign ctl = '{en: pipe_en, vld: vld_s2};

	tmff_atan_pipe #(
		.STAGES (CORDIC_STAGES),
		.W      (ATAN1_W),
		.SIDE_W (MU_W + BX_W)
	) u_atan_bx (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.y_in     (a1_y),
		.side_in  ({mu_s2, bx_s2}),
		.vld_out  (a1_vld),
		.z_out    (a1_z),
		.side_out (a1_side)
	);

	tmff_atan_pipe #(
		.STAGES (CORDIC_STAGES),
		.W      (ATAN2_W),
		.SIDE_W (MU_W)
	) u_atan_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{en: pipe_en, vld: vld_s4}),
		.y_in     (a2_y),
		.side_in  (mu_s4),
		.vld_out  (a2_vld),
		.z_out    (a2_z),
		.side_out (a2_mu)
	);

	tmff_angle_reduce #(
		.SIDE_W (MU_W)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{en: pipe_en, vld: vld_s5}),
		.arg_in   (arg_s5),
		.side_in  (mu_s5),
		.vld_out  (rd_vld),
		.z_out    (rd_z),
		.side_out (rd_mu)
	);

	tmff_sin_pipe #(
		.STAGES (CORDIC_STAGES),
		.W      (SIN_W),
		.SIDE_W (MU_W)
	) u_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{en: pipe_en, vld: rd_vld}),
		.z_in     (rd_z),
		.side_in  (rd_mu),
		.vld_out  (sn_vld),
		.sin_out  (sn_y),
		.side_out (sn_mu)
	);

	// hold an unaccepted result while the pipeline advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sk_v_q <= 1'b0;
		end else if (!sk_v_q) begin
			sk_v_q <= ov_q && !res.ready;
		end else if (res.ready) begin
			sk_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_v_q && ov_q && !res.ready) begin
			sk_force_q <= force_q;
			sk_sat_q   <= sat_q;
		end
	end

	assign res.valid     = sk_v_q || ov_q;
	assign res.force_res = sk_v_q ? sk_force_q : force_q;
	assign res.saturated = sk_v_q ? sk_sat_q : sat_q;

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.saturated |-> res.force_res == FORCE_MAX || res.force_res == FORCE_MIN)
		else $error("saturated result not at a range limit");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld |-> rd_z <= ANG_W'(HALF_PI_Q30) && rd_z >= -ANG_W'(HALF_PI_Q30))
		else $error("reduced sine angle outside [-pi/2, pi/2]");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> res.valid)
		else $error("input stalled with no result pending");

endmodule
